// ===== sv/lspf_pkg.sv =====
`default_nettype none
package lspf_pkg;

  localparam int TIME_W  = 32;
  localparam int NOW_W   = 31;
  localparam int PER_W   = 20;
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 32;
  localparam int NUM_W   = BYTE_W + PER_W;
  localparam int SLOT_W  = 5;

  localparam logic CMD_SPAWN  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // one pool entry as held in the slot memory
  typedef struct packed {
    logic [NOW_W-1:0]   start_t;
    logic [TIME_W-1:0]  end_t;
    logic [TIME_W-1:0]  fade_b;
    logic [PER_W-1:0]   per;
    logic [COLOR_W-1:0] color;
    logic               alpha_only;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_MUL,
    S_DIV,
    S_PUSH,
    S_FIN,
    S_WR
  } state_t;

endpackage
`default_nettype wire

// ===== sv/lspf_div.sv =====
`default_nettype none
module lspf_div
  import lspf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [PER_W-1:0]  den,
  output logic                   busy,
  output logic                   done,
  output logic [BYTE_W-1:0]      quo
);

  logic [NUM_W-1:0]          rem_r;
  logic [NUM_W-2:0]          dsh_r;
  logic [BYTE_W-1:0]         q_r;
  logic [$clog2(BYTE_W)-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      ge;

  // one quotient bit per cycle, msb first
  assign ge = rem_r >= {1'b0, dsh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(BYTE_W))'(BYTE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, (BYTE_W-1)'(0)};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - {1'b0, dsh_r};
      end
      q_r   <= {q_r[BYTE_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

// ===== sv/lifetime_slot_pool_with_fade.sv =====
// spawn: reads the slots in turn (S_RD, S_EV) until an expired slot turns up or the last slot is read,
//   then writes the entry and loads the result in S_WR, then returns to S_IDLE and raises in_ready
// render: S_RD and S_EV per slot, S_PUSH per live slot, S_MUL and S_DIV per faded byte
//   in the shared divider (one or three bytes per faded entry), S_FIN for the last result;
//   one item in flight, in_ready low meanwhile; every result waits while out_ready is low
// reset (synchronous, rst_n low) clears all slot valid bits at once: every slot reads as zero
`default_nettype none
module lifetime_slot_pool_with_fade
  import lspf_pkg::*;
#(
  parameter int POOL_SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic [NOW_W-1:0]  in_now,
  input  wire logic [PER_W-1:0]  in_lifetime_ms,
  input  wire logic [PER_W-1:0]  in_fade_ms,
  input  wire logic [BYTE_W-1:0] in_red_in,
  input  wire logic [BYTE_W-1:0] in_green_in,
  input  wire logic [BYTE_W-1:0] in_blue_in,
  input  wire logic [BYTE_W-1:0] in_alpha_in,
  input  wire logic              in_fade_alpha_only,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [BYTE_W-1:0]      out_red_out,
  output logic [BYTE_W-1:0]      out_green_out,
  output logic [BYTE_W-1:0]      out_blue_out,
  output logic [BYTE_W-1:0]      out_alpha_out,
  output logic                   out_live,
  output logic                   out_last
);

  localparam int IW = $clog2(POOL_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SLOTS - 1);

  state_t state_r, state_nxt;

  // latched item
  logic               cmd_r;
  logic [NOW_W-1:0]   now_r;
  logic [PER_W-1:0]   life_r;
  logic [PER_W-1:0]   fade_r;
  logic [COLOR_W-1:0] rgba_r;
  logic               ao_in_r;

  // scan state
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      pick_r;
  logic [NOW_W-1:0]   oldest_r;
  logic [COLOR_W-1:0] cur_r;
  logic [PER_W-1:0]   rem_r;
  logic [PER_W-1:0]   per_r;
  logic               ao_r;
  logic [1:0]         bsel_r;
  logic               pend_v_r;
  logic [IW-1:0]      pend_slot_r;
  logic [COLOR_W-1:0] pend_col_r;

  // slot memory
  entry_t             mem [POOL_SLOTS];
  entry_t             rdat_r;
  entry_t             ent;
  entry_t             wdat;
  logic [POOL_SLOTS-1:0] vld_r;

  // result register
  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COLOR_W-1:0] out_col_r;
  logic               out_live_r;
  logic               out_last_r;

  // control
  logic               out_free;
  logic               in_acc;
  logic               mem_we;
  logic               out_ld;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [BYTE_W-1:0]  div_q;
  logic [NUM_W-1:0]   div_num;
  logic [TIME_W-1:0]  now32;
  logic               expired;
  logic               in_fade;
  logic               idx_end;
  logic [BYTE_W-1:0]  cur_byte;
  logic [PER_W-1:0]   per_w;
  logic [TIME_W-1:0]  end_w;

  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign now32    = {1'b0, now_r};
  assign ent      = vld_r[idx_r] ? rdat_r : '0;
  assign expired  = ent.end_t <= now32;
  assign in_fade  = (ent.fade_b < now32) && (ent.per != '0);
  assign idx_end  = idx_r == LAST_IDX;
  assign cur_byte = cur_r[bsel_r*BYTE_W +: BYTE_W];
  assign div_num  = NUM_W'(cur_byte) * NUM_W'(rem_r);

  // new entry for a spawn
  assign per_w = (fade_r < life_r) ? fade_r : life_r;
  assign end_w = now32 + {{(TIME_W-PER_W){1'b0}}, life_r};
  always_comb begin
    wdat.start_t    = now_r;
    wdat.end_t      = end_w;
    wdat.fade_b     = end_w - {{(TIME_W-PER_W){1'b0}}, per_w};
    wdat.per        = per_w;
    wdat.color      = rgba_r;
    wdat.alpha_only = ao_in_r;
  end

  // shared fade divider
  lspf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (per_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD:   state_nxt = S_EV;
      S_EV: begin
        if (cmd_r == CMD_SPAWN) begin
          if (expired || idx_end) state_nxt = S_WR;
          else state_nxt = S_RD;
        end else if (expired) begin
          state_nxt = idx_end ? S_FIN : S_RD;
        end else if (in_fade) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_MUL:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = (ao_r || bsel_r == 2'd2) ? S_PUSH : S_MUL;
      end
      S_PUSH: begin
        if (!pend_v_r || out_free) state_nxt = idx_end ? S_FIN : S_RD;
      end
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      S_WR:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    out_ld    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_MUL:  div_start = 1'b1;
      S_PUSH: out_ld = pend_v_r && out_free;
      S_FIN:  out_ld = out_free;
      S_WR: begin
        out_ld = out_free;
        mem_we = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[pick_r] <= wdat;
    rdat_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (mem_we) vld_r[pick_r] <= 1'b1;
  end

  // item latch and scan datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_v_r <= 1'b0;
      end else if (state_r == S_PUSH && (!pend_v_r || out_free)) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_command;
      now_r    <= in_now;
      life_r   <= in_lifetime_ms;
      fade_r   <= in_fade_ms;
      rgba_r   <= {in_alpha_in, in_blue_in, in_green_in, in_red_in};
      ao_in_r  <= in_fade_alpha_only;
      idx_r    <= '0;
      pick_r   <= '0;
      oldest_r <= in_now;
    end
    unique case (state_r)
      S_EV: begin
        cur_r  <= ent.color;
        rem_r  <= PER_W'(ent.end_t - now32);
        per_r  <= ent.per;
        ao_r   <= ent.alpha_only;
        bsel_r <= ent.alpha_only ? 2'd3 : 2'd0;
        if (cmd_r == CMD_SPAWN) begin
          if (expired) begin
            pick_r <= idx_r;
          end else begin
            if (ent.start_t < oldest_r) begin
              oldest_r <= ent.start_t;
              pick_r   <= idx_r;
            end
            if (!idx_end) idx_r <= idx_r + 1'b1;
          end
        end else if (expired && !idx_end) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cur_r[bsel_r*BYTE_W +: BYTE_W] <= div_q;
          bsel_r <= bsel_r + 1'b1;
        end
      end
      S_PUSH: begin
        if (!pend_v_r || out_free) begin
          pend_slot_r <= idx_r;
          pend_col_r  <= cur_r;
          if (!idx_end) idx_r <= idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register, loaded when empty or while the previous result leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      unique case (state_r)
        S_WR: begin
          out_slot_r <= SLOT_W'(pick_r);
          out_col_r  <= rgba_r;
          out_live_r <= 1'b1;
          out_last_r <= 1'b1;
        end
        S_FIN: begin
          out_slot_r <= pend_v_r ? SLOT_W'(pend_slot_r) : '0;
          out_col_r  <= pend_v_r ? pend_col_r : '0;
          out_live_r <= pend_v_r;
          out_last_r <= 1'b1;
        end
        default: begin
          out_slot_r <= SLOT_W'(pend_slot_r);
          out_col_r  <= pend_col_r;
          out_live_r <= 1'b1;
          out_last_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_red_out   = out_col_r[0 +: BYTE_W];
  assign out_green_out = out_col_r[BYTE_W +: BYTE_W];
  assign out_blue_out  = out_col_r[2*BYTE_W +: BYTE_W];
  assign out_alpha_out = out_col_r[3*BYTE_W +: BYTE_W];
  assign out_live      = out_live_r;
  assign out_last      = out_last_r;

  // checks
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");

  a_dead_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_live |-> out_last)
    else $error("empty result without last");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_RD)
    else $error("transfer did not start a scan");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
